// File: hw/rtl/frame_rate_limiter_top_macros.svh
// Assertion helpers for the checker file.
`ifndef FRAME_RATE_LIMITER_TOP_MACROS_SVH
`define FRAME_RATE_LIMITER_TOP_MACROS_SVH

// Same-cycle implication.
`define FRL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the next cycle.
`define FRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked later than the antecedent.
`define FRL_ASSERT_LATER(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/frl_pkg.sv
package frl_pkg;

  localparam int TS_W       = 64;
  localparam int RATE_W     = 6;
  localparam int IV_W       = 30;
  localparam int DIG_W      = 4;
  localparam int NUM_DIG    = TS_W / DIG_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIG);
  localparam int DIV_CNT_W  = $clog2(TS_W);

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(30);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DECIDE,
    ST_DIV,
    ST_SUB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic take;
    logic last_dig;
    logic div_go;
    logic emit;
  } ctrl_t;

  // 1e9 / rate, truncated; rate 0 maps to 0, and its frames skip the arithmetic
  function automatic logic [IV_W-1:0] interval_of(input logic [RATE_W-1:0] rate);
    logic [IV_W-1:0] iv;
    unique case (rate)
      6'd1:  iv = 30'd1000000000;
      6'd2:  iv = 30'd500000000;
      6'd3:  iv = 30'd333333333;
      6'd4:  iv = 30'd250000000;
      6'd5:  iv = 30'd200000000;
      6'd6:  iv = 30'd166666666;
      6'd7:  iv = 30'd142857142;
      6'd8:  iv = 30'd125000000;
      6'd9:  iv = 30'd111111111;
      6'd10: iv = 30'd100000000;
      6'd11: iv = 30'd90909090;
      6'd12: iv = 30'd83333333;
      6'd13: iv = 30'd76923076;
      6'd14: iv = 30'd71428571;
      6'd15: iv = 30'd66666666;
      6'd16: iv = 30'd62500000;
      6'd17: iv = 30'd58823529;
      6'd18: iv = 30'd55555555;
      6'd19: iv = 30'd52631578;
      6'd20: iv = 30'd50000000;
      6'd21: iv = 30'd47619047;
      6'd22: iv = 30'd45454545;
      6'd23: iv = 30'd43478260;
      6'd24: iv = 30'd41666666;
      6'd25: iv = 30'd40000000;
      6'd26: iv = 30'd38461538;
      6'd27: iv = 30'd37037037;
      6'd28: iv = 30'd35714285;
      6'd29: iv = 30'd34482758;
      6'd30: iv = 30'd33333333;
      6'd31: iv = 30'd32258064;
      6'd32: iv = 30'd31250000;
      6'd33: iv = 30'd30303030;
      6'd34: iv = 30'd29411764;
      6'd35: iv = 30'd28571428;
      6'd36: iv = 30'd27777777;
      6'd37: iv = 30'd27027027;
      6'd38: iv = 30'd26315789;
      6'd39: iv = 30'd25641025;
      6'd40: iv = 30'd25000000;
      6'd41: iv = 30'd24390243;
      6'd42: iv = 30'd23809523;
      6'd43: iv = 30'd23255813;
      6'd44: iv = 30'd22727272;
      6'd45: iv = 30'd22222222;
      6'd46: iv = 30'd21739130;
      6'd47: iv = 30'd21276595;
      6'd48: iv = 30'd20833333;
      6'd49: iv = 30'd20408163;
      6'd50: iv = 30'd20000000;
      6'd51: iv = 30'd19607843;
      6'd52: iv = 30'd19230769;
      6'd53: iv = 30'd18867924;
      6'd54: iv = 30'd18518518;
      6'd55: iv = 30'd18181818;
      6'd56: iv = 30'd17857142;
      6'd57: iv = 30'd17543859;
      6'd58: iv = 30'd17241379;
      6'd59: iv = 30'd16949152;
      6'd60: iv = 30'd16666666;
      6'd61: iv = 30'd16393442;
      6'd62: iv = 30'd16129032;
      6'd63: iv = 30'd15873015;
      default: iv = '0;
    endcase
    return iv;
  endfunction

endpackage

// File: hw/rtl/frl_divider.sv
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module frl_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [frl_pkg::TS_W-1:0]     dividend,
  input  logic [frl_pkg::IV_W-1:0]     divisor,
  output logic                         done,
  output logic [frl_pkg::IV_W-1:0]     rem
);

  logic                           busy;
  logic [frl_pkg::DIV_CNT_W-1:0]  cnt;
  logic [frl_pkg::TS_W-1:0]       dvd;
  logic [frl_pkg::IV_W:0]         trial;
  logic [frl_pkg::IV_W:0]         diff;
  logic                           fits;

  assign trial = {rem, dvd[frl_pkg::TS_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == frl_pkg::DIV_CNT_W'(frl_pkg::TS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[frl_pkg::TS_W-2:0], 1'b0};
      rem <= fits ? diff[frl_pkg::IV_W-1:0] : trial[frl_pkg::IV_W-1:0];
    end
  end

endmodule

// File: hw/rtl/frame_rate_limiter_top.sv
// Restart, non-positive timestamp or rate 0: from idle straight to ST_FIN, which emits once the output is free.
// First frame, far-behind restart or early (dropped) frame: ST_ADD pass, ST_DECIDE, then ST_FIN.
// Late frame: also ST_DIV and ST_SUB; 64-step serial remainder plus two 16-digit nibble-serial passes.
// One frame in flight: the next transfer is taken once the result of the last has been emitted.
// Synchronous reset: rate 30, no schedule, output empty, no drop pending.
module frame_rate_limiter_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [frl_pkg::RATE_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              restart,
  input  logic signed [frl_pkg::TS_W-1:0]   presentation_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              drop
);

  frl_pkg::state_t state, state_next;
  frl_pkg::ctrl_t  ctrl;

  logic [frl_pkg::RATE_W-1:0]     fps;
  logic [frl_pkg::TS_W-1:0]       deadline;
  logic                           sched;
  logic [frl_pkg::TS_W-1:0]       ts_sh;
  logic [frl_pkg::TS_W-1:0]       dl_sh;
  logic [frl_pkg::TS_W-1:0]       iv_sh;
  logic [frl_pkg::TS_W-1:0]       sum_sh;
  logic [frl_pkg::TS_W-1:0]       diff_sh;
  logic [frl_pkg::IV_W-1:0]       iv;
  logic                           c_sum;
  logic                           b_diff;
  logic                           b_lt;
  logic                           b_sub;
  logic [frl_pkg::DIG_CNT_W-1:0]  dig_cnt;
  logic                           res_drop;
  logic                           trivial;

  logic [frl_pkg::DIG_W:0] add_d;
  logic [frl_pkg::DIG_W:0] diff_d;
  logic [frl_pkg::DIG_W:0] lt_d;
  logic [frl_pkg::DIG_W:0] sub_d;

  logic                       div_done;
  logic [frl_pkg::IV_W-1:0]   div_rem;

  assign trivial = (presentation_time == '0) || presentation_time[frl_pkg::TS_W-1]
                   || (fps == '0);

  // nibble-serial arithmetic, least significant digit first
  assign add_d  = {1'b0, ts_sh[frl_pkg::DIG_W-1:0]} + {1'b0, iv_sh[frl_pkg::DIG_W-1:0]}
                  + {{frl_pkg::DIG_W{1'b0}}, c_sum};
  assign diff_d = {1'b0, ts_sh[frl_pkg::DIG_W-1:0]} - {1'b0, dl_sh[frl_pkg::DIG_W-1:0]}
                  - {{frl_pkg::DIG_W{1'b0}}, b_diff};
  assign lt_d   = {1'b0, add_d[frl_pkg::DIG_W-1:0]} - {1'b0, dl_sh[frl_pkg::DIG_W-1:0]}
                  - {{frl_pkg::DIG_W{1'b0}}, b_lt};
  assign sub_d  = {1'b0, sum_sh[frl_pkg::DIG_W-1:0]} - {1'b0, iv_sh[frl_pkg::DIG_W-1:0]}
                  - {{frl_pkg::DIG_W{1'b0}}, b_sub};

  frl_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_go),
    .dividend (diff_sh),
    .divisor  (iv),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    ctrl          = '0;
    ctrl.take     = (state == frl_pkg::ST_IDLE) && in_valid;
    ctrl.last_dig = dig_cnt == frl_pkg::DIG_CNT_W'(frl_pkg::NUM_DIG - 1);
    ctrl.div_go   = (state == frl_pkg::ST_DECIDE) && sched && !b_lt && !b_diff;
    ctrl.emit     = (state == frl_pkg::ST_FIN) && (!out_valid || !out_stall);
    in_stall      = state != frl_pkg::ST_IDLE;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      frl_pkg::ST_IDLE: begin
        if (ctrl.take) begin
          state_next = (restart || trivial) ? frl_pkg::ST_FIN : frl_pkg::ST_ADD;
        end
      end
      frl_pkg::ST_ADD: begin
        if (ctrl.last_dig) state_next = frl_pkg::ST_DECIDE;
      end
      frl_pkg::ST_DECIDE: begin
        state_next = ctrl.div_go ? frl_pkg::ST_DIV : frl_pkg::ST_FIN;
      end
      frl_pkg::ST_DIV: begin
        if (div_done) state_next = frl_pkg::ST_SUB;
      end
      frl_pkg::ST_SUB: begin
        if (ctrl.last_dig) state_next = frl_pkg::ST_FIN;
      end
      frl_pkg::ST_FIN: begin
        if (ctrl.emit) state_next = frl_pkg::ST_IDLE;
      end
      default: state_next = frl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= frl_pkg::ST_IDLE;
      fps       <= frl_pkg::RATE_RESET;
      sched     <= 1'b0;
      out_valid <= 1'b0;
      dig_cnt   <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) fps <= cfg_wr_data;

      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (ctrl.take) begin
        dig_cnt <= '0;
        if (restart) sched <= 1'b0;
      end else if (state == frl_pkg::ST_ADD || state == frl_pkg::ST_SUB) begin
        dig_cnt <= dig_cnt + 1'b1;
      end else if (state == frl_pkg::ST_DECIDE) begin
        dig_cnt <= '0;
        if (!sched || b_lt) sched <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline <= '0;
    end else if (state == frl_pkg::ST_DECIDE && (!sched || b_lt)) begin
      // empty schedule or far behind: restart at timestamp + interval
      deadline <= sum_sh;
    end else if (state == frl_pkg::ST_SUB) begin
      // late frame: deadline = timestamp + interval - (timestamp - deadline) mod interval
      deadline <= {sub_d[frl_pkg::DIG_W-1:0], deadline[frl_pkg::TS_W-1:frl_pkg::DIG_W]};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.emit) drop <= res_drop;

    unique case (state)
      frl_pkg::ST_IDLE: begin
        ts_sh    <= presentation_time;
        dl_sh    <= deadline;
        iv       <= frl_pkg::interval_of(fps);
        iv_sh    <= {{(frl_pkg::TS_W - frl_pkg::IV_W){1'b0}}, frl_pkg::interval_of(fps)};
        c_sum    <= 1'b0;
        b_diff   <= 1'b0;
        b_lt     <= 1'b0;
        res_drop <= 1'b0;
      end
      frl_pkg::ST_ADD: begin
        ts_sh   <= ts_sh >> frl_pkg::DIG_W;
        dl_sh   <= dl_sh >> frl_pkg::DIG_W;
        iv_sh   <= iv_sh >> frl_pkg::DIG_W;
        sum_sh  <= {add_d[frl_pkg::DIG_W-1:0], sum_sh[frl_pkg::TS_W-1:frl_pkg::DIG_W]};
        diff_sh <= {diff_d[frl_pkg::DIG_W-1:0], diff_sh[frl_pkg::TS_W-1:frl_pkg::DIG_W]};
        c_sum   <= add_d[frl_pkg::DIG_W];
        b_diff  <= diff_d[frl_pkg::DIG_W];
        b_lt    <= lt_d[frl_pkg::DIG_W];
      end
      frl_pkg::ST_DECIDE: begin
        b_sub <= 1'b0;
        // live schedule, not far behind, timestamp short of the deadline
        if (sched && !b_lt && b_diff) res_drop <= 1'b1;
      end
      frl_pkg::ST_DIV: begin
        if (div_done) begin
          iv_sh <= {{(frl_pkg::TS_W - frl_pkg::IV_W){1'b0}}, div_rem};
        end
      end
      frl_pkg::ST_SUB: begin
        sum_sh <= sum_sh >> frl_pkg::DIG_W;
        iv_sh  <= iv_sh >> frl_pkg::DIG_W;
        b_sub  <= sub_d[frl_pkg::DIG_W];
      end
      frl_pkg::ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/frl_checker.sv
`include "frame_rate_limiter_top_macros.svh"

module frl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              restart,
  input logic signed [frl_pkg::TS_W-1:0]   presentation_time,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              drop
);

  logic in_xfer;
  logic out_free;
  logic out_held;
  logic restart_take;
  logic neg_take;
  logic pass_now;

  assign in_xfer      = in_valid && !in_stall;
  assign out_free     = !out_valid;
  assign out_held     = out_valid && out_stall;
  assign restart_take = in_xfer && restart && out_free;
  assign neg_take     = in_xfer && !restart && presentation_time[frl_pkg::TS_W-1] && out_free;
  assign pass_now     = out_valid && !drop;

  `FRL_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(drop), "stalled result changed")

  `FRL_ASSERT_NEXT(a_one_in_flight, in_xfer, in_stall, "second frame taken while one in flight")

  `FRL_ASSERT_LATER(a_restart_pass, restart_take, pass_now, "restart frame not passed on time")

  `FRL_ASSERT_LATER(a_neg_ts_pass, neg_take, pass_now, "negative timestamp not passed on time")

endmodule

bind frame_rate_limiter_top frl_checker u_frl_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Tracks the schedule deadline and the drop decisions still owed by the block.
  class drop_tracker;
    logic [frl_pkg::RATE_W-1:0] rate;
    logic [frl_pkg::TS_W-1:0]   sched_deadline;
    bit                         pending_drops[$];
    int                         errors;

    function new();
      rate = frl_pkg::RATE_RESET;
      sched_deadline = '0;
      errors = 0;
    endfunction

    function bit predict_drop(input logic rs, input logic [frl_pkg::TS_W-1:0] ts);
      logic [frl_pkg::TS_W-1:0] period, steps, room;
      if (rs) begin
        sched_deadline = '0;
        return 1'b0;
      end
      // zero or negative timestamp, or dropping disabled: pass, state kept
      if (ts == '0 || ts[frl_pkg::TS_W-1] || rate == '0)
        return 1'b0;
      period = 64'd1_000_000_000 / {{(frl_pkg::TS_W-frl_pkg::RATE_W){1'b0}}, rate};
      if (sched_deadline == '0 || ts + period < sched_deadline) begin
        sched_deadline = ts + period;
        return 1'b0;
      end
      if (ts < sched_deadline)
        return 1'b1;
      steps = (ts - sched_deadline) / period + 64'd1;
      room = (~64'd0 - sched_deadline) / period;
      if (steps > room)
        sched_deadline = ts + period;
      else
        sched_deadline = sched_deadline + steps * period;
      return 1'b0;
    endfunction

    function void note_frame(input logic rs, input logic [frl_pkg::TS_W-1:0] ts);
      pending_drops.push_back(predict_drop(rs, ts));
    endfunction

    function void check_drop(input logic got);
      bit want;
      if (pending_drops.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result transfer: drop=%0b", got);
        return;
      end
      want = pending_drops.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("drop mismatch: expected %0b, got %0b", want, got);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [frl_pkg::RATE_W-1:0]       cfg_wr_data;
  logic                             in_valid;
  logic                             in_stall;
  logic                             restart;
  logic signed [frl_pkg::TS_W-1:0]  presentation_time;
  logic                             out_valid;
  logic                             out_stall;
  logic                             drop;

  drop_tracker sb;
  int          cycles;
  int          stall_left;
  bit          calm;

  frame_rate_limiter_top DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .restart           (restart),
    .presentation_time (presentation_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .drop              (drop)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // transfer monitor: values read here are the ones the block saw at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_frame(restart, presentation_time);
      if (out_valid && !out_stall)
        sb.check_drop(drop);
    end
  end

  // receiver back-pressure: mostly short bursts, now and then a long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall || calm) begin
      out_stall = 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_stall = 1'b1;
      case ($urandom_range(0, 19))
        0:       stall_left = $urandom_range(30, 80);
        1, 2:    stall_left = $urandom_range(4, 15);
        default: stall_left = $urandom_range(0, 3);
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_frame(input logic rs, input logic [frl_pkg::TS_W-1:0] ts);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    restart = rs;
    presentation_time = ts;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_drops.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_rate(input logic [frl_pkg::RATE_W-1:0] r);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = r;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.rate = r;
  endtask

  task automatic run_phase(input logic [frl_pkg::RATE_W-1:0] r, input int n);
    logic [frl_pkg::TS_W-1:0] t, period, step;
    int                       pick;
    wait_idle();
    set_rate(r);
    period = (r == '0) ? 64'd33_333_333 : 64'd1_000_000_000 / {58'd0, r};
    case ($urandom_range(0, 3))
      0:       t = 64'($urandom_range(1, 1000));
      1:       t = 64'h7FFF_FFFF_FFFF_FFFF - period * $urandom_range(1, 40);
      default: t = {2'b00, 30'($urandom), 32'($urandom)};
    endcase
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0)
        calm = ($urandom_range(0, 3) == 0);
      if (i == n / 2)
        wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 15 && sb.sched_deadline != '0 && !sb.sched_deadline[frl_pkg::TS_W-1]
          && sb.sched_deadline > period + 2) begin
        // land right on the schedule edges
        case ($urandom_range(0, 4))
          0: t = sb.sched_deadline - 1;
          1: t = sb.sched_deadline;
          2: t = sb.sched_deadline + 1;
          3: t = sb.sched_deadline - period - 1;
          default: t = sb.sched_deadline - period;
        endcase
        send_frame(1'b0, t);
      end else if (pick < 65) begin
        if ($urandom_range(0, 9) == 0)
          step = period * $urandom_range(2, 60) + 64'($urandom_range(0, 999));
        else
          step = {$urandom, $urandom} % (period * 2);
        t = t + step;
        if (t[frl_pkg::TS_W-1])
          t = 64'($urandom_range(1, 1000));
        send_frame(1'b0, t);
      end else if (pick < 72) begin
        send_frame(1'b1, {$urandom, $urandom});
      end else if (pick < 80) begin
        if (t > period * 8)
          t = t - period * $urandom_range(2, 4);
        send_frame(1'b0, t);
      end else if (pick < 86) begin
        send_frame(1'b0, $urandom_range(0, 1) ? 64'd0 : {1'b1, 31'($urandom), 32'($urandom)});
      end else if (pick < 93) begin
        send_frame(1'b0, {$urandom, $urandom});
      end else begin
        t = t + {16'd0, 32'($urandom), 16'($urandom)};
        if (t[frl_pkg::TS_W-1])
          t = 64'($urandom_range(1, 1000));
        send_frame(1'b0, t);
      end
    end
  endtask

  initial begin
    logic [frl_pkg::TS_W-1:0]   top_ts;
    logic [frl_pkg::RATE_W-1:0] rates[10];
    sb = new();
    cycles = 0;
    stall_left = 0;
    calm = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    presentation_time = '0;
    out_stall = 1'b0;
    top_ts = 64'h7FFF_FFFF_FFFF_FFFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset rate of 30, interval 33333333
    send_frame(1'b0, 64'd1);                         // empty schedule
    send_frame(1'b0, 64'd100);                       // early, dropped
    send_frame(1'b0, 64'd0);                         // zero timestamp
    send_frame(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);       // -1
    send_frame(1'b0, 64'h8000_0000_0000_0000);       // most negative
    send_frame(1'b0, 64'd33_333_334);                // exactly on the deadline
    send_frame(1'b0, 64'd66_666_667 + 64'd33_333_333 * 5 + 64'd7);  // several intervals late
    send_frame(1'b0, 64'd266_666_664);               // just short of the deadline
    send_frame(1'b0, top_ts);                        // huge jump ahead
    send_frame(1'b0, top_ts);                        // early again
    send_frame(1'b0, 64'd5);                         // far behind, schedule restarts
    send_frame(1'b1, top_ts);                        // new session
    send_frame(1'b0, top_ts);
    send_frame(1'b0, top_ts - 1);
    send_frame(1'b1, 64'd0);
    wait_idle();
    set_rate(6'd1);
    send_frame(1'b0, 64'd1_000_000_000);
    send_frame(1'b0, 64'd1_999_999_999);
    wait_idle();
    set_rate(6'd63);
    send_frame(1'b0, 64'd1_000_000_001);             // far behind after rate change
    send_frame(1'b0, 64'd1_000_000_002);
    wait_idle();
    set_rate(6'd0);
    send_frame(1'b0, 64'd5);
    send_frame(1'b0, 64'd1_000_000_005);
    send_frame(1'b0, top_ts);

    rates = '{6'd63, 6'd0, 6'd1, 6'd60, 6'd30, 6'd61, 6'd2,
              6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              6'($urandom_range(0, 63))};
    foreach (rates[p])
      run_phase(rates[p], 83);

    wait_idle();
    repeat (20) @(negedge clk);
    if (sb.pending_drops.size() != 0) begin
      sb.errors++;
      $display("%0d results never arrived", sb.pending_drops.size());
    end
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
